>>> rtl/cbed_pkg.sv
// ----------------------------------------------------------------------------
// cbed_pkg: caret and backslash escape decoder shared definitions
// Transaction types, decode mode codes, character constants and the
// backslash escape letter table.
// ----------------------------------------------------------------------------
package cbed_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       is_terminator;
  } out_item_t;

  // Results caused by one input transaction, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } result_pair_t;

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_CARET   = 2'd1;
  localparam logic [1:0] MODE_ESCAPE  = 2'd2;
  localparam logic [1:0] MODE_NUMERIC = 2'd3;

  localparam logic [1:0] DIGITS_FULL = 2'd3;

  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_CARET     = 8'h5E;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CONTROL_MASK   = 8'h1F;
  localparam logic [7:0] NUL_BYTE       = 8'h00;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } escape_lookup_t;

  // Map the letter after a backslash to its control code.
  function automatic escape_lookup_t escape_code(input logic [7:0] b);
    escape_lookup_t r;
    r.hit  = 1'b1;
    r.code = b;
    case (b)
      8'h45:   r.code = 8'h1B;  // E -> ESC
      8'h5E:   r.code = 8'h5E;  // caret
      8'h5C:   r.code = 8'h5C;  // backslash
      8'h3A:   r.code = 8'h3A;  // colon
      8'h6E:   r.code = 8'h0A;  // n -> LF
      8'h72:   r.code = 8'h0D;  // r -> CR
      8'h74:   r.code = 8'h09;  // t -> TAB
      8'h62:   r.code = 8'h08;  // b -> BS
      8'h66:   r.code = 8'h0C;  // f -> FF
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cbed_decode.sv
// ----------------------------------------------------------------------------
// cbed_decode: decode state and result logic
// Holds the decode mode, numeric value and digit count, and forms the
// results of the held input transaction. State advances on step.
// ----------------------------------------------------------------------------
module cbed_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  cbed_pkg::in_item_t    item,
  output cbed_pkg::result_pair_t results
);
  import cbed_pkg::*;

  logic [1:0] mode, mode_next;
  logic [7:0] value, value_next;
  logic [1:0] digits, digits_next;

  logic           is_digit;
  logic [7:0]     digit_diff;
  logic [7:0]     digit_val;
  logic [7:0]     shifted;
  logic [1:0]     digits_inc;
  escape_lookup_t esc;

  assign is_digit   = (item.in_byte >= CHAR_ZERO) && (item.in_byte <= CHAR_NINE);
  assign digit_diff = item.in_byte - CHAR_ZERO;
  assign digit_val  = {4'd0, digit_diff[3:0]};
  assign shifted    = {value[4:0], 3'd0} | digit_val;
  assign digits_inc = digits + 2'd1;
  assign esc        = escape_code(item.in_byte);

  always_comb begin
    logic [1:0] n;
    logic [7:0] b0, b1;
    logic       t1;
    n           = 2'd0;
    b0          = NUL_BYTE;
    b1          = NUL_BYTE;
    t1          = 1'b0;
    mode_next   = mode;
    value_next  = value;
    digits_next = digits;

    if (item.end_of_text) begin
      if (mode == MODE_NUMERIC) begin
        b0 = value;
        b1 = NUL_BYTE;
        t1 = 1'b1;
        n  = 2'd2;
      end else begin
        b0 = NUL_BYTE;
        n  = 2'd1;
      end
      mode_next   = MODE_NORMAL;
      value_next  = 8'd0;
      digits_next = 2'd0;
    end else begin
      case (mode)
        MODE_CARET: begin
          mode_next = MODE_NORMAL;
          b0        = item.in_byte & CONTROL_MASK;
          n         = 2'd1;
        end
        MODE_ESCAPE: begin
          mode_next = MODE_NORMAL;
          if (esc.hit) begin
            b0 = esc.code;
            n  = 2'd1;
          end else if (is_digit) begin
            value_next  = digit_val;
            digits_next = 2'd1;
            mode_next   = MODE_NUMERIC;
          end else begin
            b0 = item.in_byte;
            n  = 2'd1;
          end
        end
        MODE_NUMERIC: begin
          if (is_digit) begin
            value_next  = shifted;
            digits_next = digits_inc;
            if ((digits_inc == DIGITS_FULL) || (digits_inc == 2'd0)) begin
              b0          = shifted;
              n           = 2'd1;
              mode_next   = MODE_NORMAL;
              value_next  = 8'd0;
              digits_next = 2'd0;
            end
          end else begin
            // Flush the value, then treat the byte as normal text.
            b0          = value;
            n           = 2'd1;
            value_next  = 8'd0;
            digits_next = 2'd0;
            if (item.in_byte == CHAR_CARET) begin
              mode_next = MODE_CARET;
            end else if (item.in_byte == CHAR_BACKSLASH) begin
              mode_next = MODE_ESCAPE;
            end else begin
              mode_next = MODE_NORMAL;
              b1        = item.in_byte;
              n         = 2'd2;
            end
          end
        end
        default: begin
          if (item.in_byte == CHAR_CARET) begin
            mode_next = MODE_CARET;
          end else if (item.in_byte == CHAR_BACKSLASH) begin
            mode_next = MODE_ESCAPE;
          end else begin
            mode_next = MODE_NORMAL;
            b0        = item.in_byte;
            n         = 2'd1;
          end
        end
      endcase
    end

    results.count                = n;
    results.first.out_byte       = b0;
    results.first.last_of_run    = (n == 2'd1);
    results.first.is_terminator  = item.end_of_text && (n == 2'd1);
    results.second.out_byte      = b1;
    results.second.last_of_run   = 1'b1;
    results.second.is_terminator = t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_NORMAL;
      value  <= 8'd0;
      digits <= 2'd0;
    end else if (step) begin
      mode   <= mode_next;
      value  <= value_next;
      digits <= digits_next;
    end
  end

endmodule

>>> rtl/cbed_result_buf.sv
// ----------------------------------------------------------------------------
// cbed_result_buf: two-slot result register
// Loads the results of one input transaction and delivers them one per
// cycle on the output handshake while result_ready is high.
// ----------------------------------------------------------------------------
module cbed_result_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  cbed_pkg::result_pair_t pair,
  output logic                   free,
  output logic                   result_valid,
  input  logic                   result_ready,
  output cbed_pkg::out_item_t    result
);
  import cbed_pkg::*;

  out_item_t  slot0, slot1;
  logic [1:0] remaining;
  logic       head;
  logic       pop;

  assign result_valid = (remaining != 2'd0);
  assign result       = head ? slot1 : slot0;
  assign pop          = result_valid && result_ready;
  // Free when empty or when the last held result leaves this cycle.
  assign free         = (remaining == 2'd0) || ((remaining == 2'd1) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      head      <= 1'b0;
    end else if (load) begin
      remaining <= pair.count;
      head      <= 1'b0;
    end else if (pop) begin
      remaining <= remaining - 2'd1;
      head      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= pair.first;
      slot1 <= pair.second;
    end
  end

endmodule

>>> rtl/caret_backslash_escape_decoder_unit.sv
// Timing: the input register holds each transaction, and its results are
//   registered in the result register once that register is free.
// Throughput: one transaction per cycle while result_ready is high and
//   each gives at most one result; a pair holds the register until both go.
// Reset: rst, synchronous, clears the decode state, the held flag and the
//   result count; payload registers are not reset.
// ----------------------------------------------------------------------------
// caret_backslash_escape_decoder_unit: termcap style string decoder
// Decodes caret control codes, backslash letter escapes and octal-like
// numeric escapes from a byte stream, closing each string with a zero byte.
// ----------------------------------------------------------------------------
module caret_backslash_escape_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  cbed_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output cbed_pkg::out_item_t result
);
  import cbed_pkg::*;

  // Input register: holds one transaction while its results are formed.
  in_item_t held;
  logic     held_valid;

  result_pair_t pair;
  logic         buf_free;
  logic         advance;
  logic         load;

  // Advance the held transaction when its results fit in the result
  // register. A transaction with no result (caret, backslash, digits
  // inside a numeric escape) only updates the decode state, so it never
  // waits on the output side.
  assign advance    = held_valid && ((pair.count == 2'd0) || buf_free);
  assign load       = advance && (pair.count != 2'd0);
  // Take a new transaction whenever the held one leaves or none is held.
  assign item_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      held <= item;
    end
  end

  // Decode state and the results of the held transaction.
  cbed_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (held),
    .results (pair)
  );

  // Result register: delivers the one or two results in order.
  cbed_result_buf u_result_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .pair         (pair),
    .free         (buf_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
